@@ hw/rtl/mie_pkg.sv @@
// ---------------------------------------------------------------------------
// mie_pkg: shared types and constants for the modular inverse block
// Widths, channel packing, sequencer states and divider status.
// ---------------------------------------------------------------------------
package mie_pkg;

  // operand width of value and modulus
  localparam int WIDTH = 32;

  // divider step counter width
  localparam int CNT_W = $clog2(WIDTH);

  // stream data widths, padded up to whole bytes
  localparam int IN_DATA_W  = ((2 * WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((WIDTH + 7) / 8) * 8;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPD,
    S_FIN
  } mie_state_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mie_div_stat_t;

endpackage

@@ hw/rtl/mie_div.sv @@
// ---------------------------------------------------------------------------
// mie_div: shared shift-subtract divider with quotient multiply-accumulate
// One quotient bit per cycle, restoring form; the same bit drives a
// shift-add product of the quotient with a multiplier operand.
// ---------------------------------------------------------------------------
module mie_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [mie_pkg::WIDTH-1:0] dividend,
  input  logic [mie_pkg::WIDTH-1:0] divisor,
  input  logic [mie_pkg::WIDTH-1:0] mult,
  output mie_pkg::mie_div_stat_t stat,
  output logic [mie_pkg::WIDTH-1:0] quot_prod,
  output logic [mie_pkg::WIDTH-1:0] remainder
);
  import mie_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [WIDTH-1:0]  rem_r;
  logic [WIDTH-1:0]  dvd_r;
  logic [WIDTH-1:0]  dsr_r;
  logic [WIDTH-1:0]  mul_r;
  logic [WIDTH-1:0]  acc_r;

  logic [WIDTH:0]    trial;
  logic [WIDTH:0]    diff;
  logic              qbit;
  logic [WIDTH-1:0]  rem_nxt;
  logic [WIDTH-1:0]  dvd_nxt;
  logic [WIDTH-1:0]  acc_nxt;

  // one restoring step plus one shift-add step
  always_comb begin
    trial   = {rem_r, dvd_r[WIDTH-1]};
    diff    = trial - {1'b0, dsr_r};
    qbit    = ~diff[WIDTH];
    rem_nxt = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    dvd_nxt = {dvd_r[WIDTH-2:0], qbit};
    acc_nxt = {acc_r[WIDTH-2:0], 1'b0} + (qbit ? mul_r : '0);
  end

  // control: busy while the step counter runs down to zero, done pulse after the last step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(WIDTH - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
      mul_r <= mult;
      acc_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= dvd_nxt;
      acc_r <= acc_nxt;
    end
  end

  assign stat.busy  = busy_r;
  assign stat.done  = done_r;
  assign quot_prod  = acc_r;
  assign remainder  = rem_r;

endmodule

@@ hw/rtl/modular_inverse_ext_euclid.sv @@
// Steps: up to about 1.44 * WIDTH + 2 Euclid steps; each step is one pass
//   of the shared bit-serial divider.
// Throughput: one item at a time; in_tready is high only while idle, and a
//   finished result may wait in the output register while a new item starts.
// Reset: synchronous, active low; clears the sequencer and the output valid.
// ---------------------------------------------------------------------------
// modular_inverse_ext_euclid: modular inverse by extended Euclid
// Iterates Euclid's remainder sequence on a shared divider and carries the
// Bezout coefficient as magnitude and alternating sign.
// ---------------------------------------------------------------------------
module modular_inverse_ext_euclid (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: value [WIDTH-1:0], modulus [2*WIDTH-1:WIDTH]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mie_pkg::IN_DATA_W-1:0] in_tdata,
  // out_tdata: inverse [WIDTH-1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mie_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: not_coprime
  output logic                          out_tuser
);
  import mie_pkg::*;

  mie_state_t    state_r;
  mie_state_t    state_nxt;

  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] b_r;
  logic [WIDTH-1:0] b0_r;
  logic [WIDTH-1:0] m1_r;
  logic [WIDTH-1:0] m0_r;
  logic             neg1_r;
  logic             err_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  logic [WIDTH-1:0] in_value;
  logic [WIDTH-1:0] in_modulus;
  logic             in_acc;
  logic             a_gt1;
  logic             b_zero;
  logic             out_free;
  logic             div_start;
  logic             upd_en;
  logic             out_load;
  logic [WIDTH-1:0] inv;

  mie_div_stat_t    div_stat;
  logic [WIDTH-1:0] div_prod;
  logic [WIDTH-1:0] div_rem;

  assign in_value   = in_tdata[WIDTH-1:0];
  assign in_modulus = in_tdata[2*WIDTH-1:WIDTH];
  assign in_acc     = in_tvalid & in_tready;
  assign a_gt1      = (a_r > WIDTH'(1));
  assign b_zero     = (b_r == '0);
  assign out_free   = ~out_valid_r | out_tready;

  // shared divider: q = a / b, r = a % b, product q * m0
  mie_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (a_r),
    .divisor   (b_r),
    .mult      (m0_r),
    .stat      (div_stat),
    .quot_prod (div_prod),
    .remainder (div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_modulus == WIDTH'(1)) ? S_FIN : S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = (a_gt1 && !b_zero) ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        state_nxt = S_CHECK;
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    upd_en    = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_CHECK: div_start = a_gt1 & ~b_zero;
      S_DIV:   ;
      S_UPD:   upd_en = 1'b1;
      S_FIN:   out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // euclid registers and bezout coefficient
  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_r    <= in_value;
      b_r    <= in_modulus;
      b0_r   <= in_modulus;
      m1_r   <= WIDTH'(1);
      m0_r   <= '0;
      neg1_r <= 1'b0;
      err_r  <= 1'b0;
    end else if (state_r == S_CHECK && a_gt1 && b_zero) begin
      err_r <= 1'b1;
    end else if (upd_en) begin
      a_r    <= b_r;
      b_r    <= div_rem;
      m1_r   <= m0_r;
      m0_r   <= div_prod + m1_r;
      neg1_r <= ~neg1_r;
    end
  end

  // sign correction of the final coefficient
  assign inv = (neg1_r && m1_r != '0) ? (b0_r - m1_r) : m1_r;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= err_r ? '0 : OUT_DATA_W'(inv);
      out_user_r <= err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

@@ hw/rtl/mie_chk.sv @@
// ---------------------------------------------------------------------------
// mie_chk: port-level checks for the modular inverse block
// Watches handshakes and result items on the top-level ports.
// ---------------------------------------------------------------------------
module mie_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [mie_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);
  import mie_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // an error item carries a zero inverse
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("not coprime item with nonzero inverse");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready right after an accepted item");

  // reset empties the output
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind modular_inverse_ext_euclid mie_chk u_mie_chk (.*);
